>>> rtl/core/acc_cpu_pkg.sv
// ----------------------------------------------------------------------------
// acc_cpu_pkg
// Shared types and constants of the accumulator processor core: request
// kinds, opcodes, status codes and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package acc_cpu_pkg;

    localparam int MEM_BYTES = 256;
    localparam int AW        = $clog2(MEM_BYTES);

    // request kinds
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EXEC  = 2'd2;

    // opcodes
    localparam logic [7:0] OP_NOP = 8'h00;
    localparam logic [7:0] OP_STA = 8'h10;
    localparam logic [7:0] OP_LDA = 8'h20;
    localparam logic [7:0] OP_ADD = 8'h30;
    localparam logic [7:0] OP_OR  = 8'h40;
    localparam logic [7:0] OP_AND = 8'h50;
    localparam logic [7:0] OP_NOT = 8'h60;
    localparam logic [7:0] OP_JMP = 8'h80;
    localparam logic [7:0] OP_JN  = 8'h90;
    localparam logic [7:0] OP_JZ  = 8'hA0;
    localparam logic [7:0] OP_HLT = 8'hF0;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic req_mem;    // memory access at the request address
        logic fetch_op;   // read opcode byte at pc
        logic fetch_arg;  // read operand byte at pc + 1
        logic data_acc;   // data access at the operand address
        logic exec;       // update architectural state
        logic out_load;   // load the result register
    } cmd_t;

    typedef struct packed {
        logic stopped;
    } sts_t;

endpackage

>>> rtl/core/acc_cpu_ifs.sv
// ----------------------------------------------------------------------------
// acc_cpu_ifs
// Request and response channels of the accumulator processor core, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface acc_cpu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] address;
    logic [7:0] write_data;

    modport source (output valid, output req_type, output address, output write_data,
                    input ready);
    modport sink   (input valid, input req_type, input address, input write_data,
                    output ready);
endinterface

interface acc_cpu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] program_count;
    logic [7:0] accum;
    logic       negative_flag;
    logic       zero_flag;
    logic [7:0] read_data;
    logic [1:0] status;

    modport source (output valid, output program_count, output accum,
                    output negative_flag, output zero_flag, output read_data,
                    output status, input ready);
    modport sink   (input valid, input program_count, input accum,
                    input negative_flag, input zero_flag, input read_data,
                    input status, output ready);
endinterface

>>> rtl/core/acc_cpu_ctrl.sv
// ----------------------------------------------------------------------------
// acc_cpu_ctrl
// Sequencer of the core: accepts a request, steps the datapath through the
// memory access or the instruction phases and hands the result to the
// response register.
// ----------------------------------------------------------------------------
module acc_cpu_ctrl
    import acc_cpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] req_type,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output cmd_t       cmd,
    input  sts_t       sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEM,
        S_FETCH_OP,
        S_FETCH_ARG,
        S_DATA,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   req_xfer;
    logic   out_free;

    assign req_ready = (state_reg == S_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd.load_req = 1'b1;
                    case (req_type)
                        REQ_WRITE, REQ_READ: state_next = S_MEM;
                        REQ_EXEC:   state_next = sts.stopped ? S_DONE : S_FETCH_OP;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_MEM:
            begin
                cmd.req_mem = 1'b1;
                state_next  = S_DONE;
            end
            S_FETCH_OP:
            begin
                cmd.fetch_op = 1'b1;
                state_next   = S_FETCH_ARG;
            end
            S_FETCH_ARG:
            begin
                cmd.fetch_arg = 1'b1;
                state_next    = S_DATA;
            end
            S_DATA:
            begin
                cmd.data_acc = 1'b1;
                state_next   = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/acc_cpu_dp.sv
// ----------------------------------------------------------------------------
// acc_cpu_dp
// Datapath of the core: 256-byte single-port memory with per-byte valid
// bits, program counter, accumulator, flags, instruction execution and the
// response register.
// ----------------------------------------------------------------------------
module acc_cpu_dp
    import acc_cpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output sts_t       sts,
    input  logic [1:0] req_type,
    input  logic [7:0] address,
    input  logic [7:0] write_data,
    output logic [7:0] program_count,
    output logic [7:0] accum,
    output logic       negative_flag,
    output logic       zero_flag,
    output logic [7:0] read_data,
    output logic [1:0] status
);

    logic [7:0]     mem [MEM_BYTES];
    logic [MEM_BYTES-1:0] vld_reg;

    logic [1:0]     type_reg;
    logic [AW-1:0]  addr_reg;
    logic [7:0]     wdata_reg;
    logic [7:0]     opc_reg;
    logic [7:0]     opr_reg;
    logic [7:0]     rd_q_reg;
    logic           rd_vld_reg;
    logic [7:0]     mem_q;

    logic [7:0]     pc_reg, pc_next;
    logic [7:0]     acc_reg, acc_next;
    logic           neg_reg, neg_next;
    logic           zero_reg, zero_next;
    logic           stop_reg, stop_next;
    logic [1:0]     st_reg, st_next;

    logic [7:0]     out_pc_reg;
    logic [7:0]     out_acc_reg;
    logic           out_neg_reg;
    logic           out_zero_reg;
    logic [7:0]     out_rd_reg;
    logic [1:0]     out_st_reg;

    logic [AW-1:0]  mem_addr;
    logic           mem_rd;
    logic           mem_wr;
    logic [7:0]     mem_wdata;
    logic [7:0]     pc_inc1;
    logic [7:0]     pc_inc2;
    logic           set_flags;

    assign mem_q   = rd_vld_reg ? rd_q_reg : 8'h00;
    assign pc_inc1 = pc_reg + 8'd1;
    assign pc_inc2 = pc_reg + 8'd2;
    assign sts.stopped = stop_reg;

    // memory port select
    always_comb
    begin
        mem_addr  = addr_reg;
        mem_rd    = 1'b0;
        mem_wr    = 1'b0;
        mem_wdata = wdata_reg;
        if (cmd.req_mem)
        begin
            mem_addr = addr_reg;
            mem_wr   = (type_reg == REQ_WRITE);
            mem_rd   = (type_reg == REQ_READ);
        end
        else if (cmd.fetch_op)
        begin
            mem_addr = pc_reg;
            mem_rd   = 1'b1;
        end
        else if (cmd.fetch_arg)
        begin
            mem_addr = pc_inc1;
            mem_rd   = 1'b1;
        end
        else if (cmd.data_acc)
        begin
            mem_addr  = mem_q;
            mem_wdata = acc_reg;
            mem_wr    = (opc_reg == OP_STA);
            mem_rd    = (opc_reg != OP_STA);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            rd_q_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (mem_wr)
            begin
                vld_reg[mem_addr] <= 1'b1;
            end
            if (mem_rd)
            begin
                rd_vld_reg <= vld_reg[mem_addr];
            end
        end
    end

    // request capture and instruction bytes
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            type_reg  <= req_type;
            addr_reg  <= address;
            wdata_reg <= write_data;
        end
        if (cmd.fetch_arg)
        begin
            opc_reg <= mem_q;
        end
        if (cmd.data_acc)
        begin
            opr_reg <= mem_q;
        end
    end

    // instruction execution
    always_comb
    begin
        pc_next   = pc_reg;
        acc_next  = acc_reg;
        stop_next = stop_reg;
        st_next   = st_reg;
        set_flags = 1'b0;
        if (cmd.load_req)
        begin
            st_next = (req_type == REQ_EXEC && stop_reg) ? ST_IGNORED : ST_OK;
        end
        else if (cmd.exec)
        begin
            case (opc_reg)
                OP_NOP: pc_next = pc_inc1;
                OP_STA: pc_next = pc_inc2;
                OP_LDA:
                begin
                    acc_next  = mem_q;
                    set_flags = 1'b1;
                    pc_next   = pc_inc2;
                end
                OP_ADD:
                begin
                    acc_next  = acc_reg + mem_q;
                    set_flags = 1'b1;
                    pc_next   = pc_inc2;
                end
                OP_OR:
                begin
                    acc_next  = acc_reg | mem_q;
                    set_flags = 1'b1;
                    pc_next   = pc_inc2;
                end
                OP_AND:
                begin
                    acc_next  = acc_reg & mem_q;
                    set_flags = 1'b1;
                    pc_next   = pc_inc2;
                end
                OP_NOT:
                begin
                    acc_next  = ~acc_reg;
                    set_flags = 1'b1;
                    pc_next   = pc_inc1;
                end
                OP_JMP: pc_next = opr_reg;
                OP_JN:  pc_next = neg_reg ? opr_reg : pc_inc2;
                OP_JZ:  pc_next = zero_reg ? opr_reg : pc_inc2;
                OP_HLT:
                begin
                    stop_next = 1'b1;
                    st_next   = ST_HALT;
                end
                default:
                begin
                    stop_next = 1'b1;
                    st_next   = ST_UNKNOWN;
                end
            endcase
        end
        neg_next  = set_flags ? acc_next[7] : neg_reg;
        zero_next = set_flags ? (acc_next == 8'h00) : zero_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            zero_reg <= 1'b0;
            stop_reg <= 1'b0;
            st_reg   <= ST_OK;
        end
        else
        begin
            pc_reg   <= pc_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
            stop_reg <= stop_next;
            st_reg   <= st_next;
        end
    end

    // response register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pc_reg   <= pc_reg;
            out_acc_reg  <= acc_reg;
            out_neg_reg  <= neg_reg;
            out_zero_reg <= zero_reg;
            out_rd_reg   <= (type_reg == REQ_READ) ? mem_q : 8'h00;
            out_st_reg   <= st_reg;
        end
    end

    assign program_count = out_pc_reg;
    assign accum         = out_acc_reg;
    assign negative_flag = out_neg_reg;
    assign zero_flag     = out_zero_reg;
    assign read_data     = out_rd_reg;
    assign status        = out_st_reg;

endmodule

>>> rtl/core/accumulator_cpu_core.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_core
// 8-bit accumulator processor with 256 bytes of memory.
//
// Channels: req (sink) carries one request per transfer: a memory byte
// write, a memory byte read or the execution of one instruction. rsp
// (source) returns exactly one result per request: pc, accumulator, N/Z
// flags, read byte (zero unless a read) and status.
// A memory read or write passes through the memory access state, an ignored
// request goes straight to the result, and an instruction steps through
// opcode fetch, operand fetch, data access, execute and result.
// The single memory port serialises the instruction phases; one request is
// in flight at a time: no new request is taken until the last is done.
// Reset clears pc, accumulator, flags and the stop state; every memory byte
// reads as zero until written, tracked by one valid bit per byte.
// A stalled receiver holds the result in the output register; the next
// request is still taken and processed, and its result waits until the
// held result transfers.
// ----------------------------------------------------------------------------
module accumulator_cpu_core
    import acc_cpu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    acc_cpu_req_if.sink   req,
    acc_cpu_rsp_if.source rsp
);

    cmd_t cmd;
    sts_t sts;

    acc_cpu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_type  (req.req_type),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    acc_cpu_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .req_type      (req.req_type),
        .address       (req.address),
        .write_data    (req.write_data),
        .program_count (rsp.program_count),
        .accum         (rsp.accum),
        .negative_flag (rsp.negative_flag),
        .zero_flag     (rsp.zero_flag),
        .read_data     (rsp.read_data),
        .status        (rsp.status)
    );

endmodule

>>> test/acc_cpu_result_checker.sv
// ----------------------------------------------------------------------------
// acc_cpu_result_checker
// Watches the request and response channels of the accumulator processor
// core. Every request transfer runs through a cycle-free model of the
// processor (memory, pc, accumulator, flags, stop state) and queues the
// expected result. Every response transfer is compared field by field with
// the oldest queued result. Hands the error count, the number of results
// still owed and the model pc to the testbench top.
// ----------------------------------------------------------------------------
module acc_cpu_result_checker
    import acc_cpu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    acc_cpu_req_if     req_mon,
    acc_cpu_rsp_if     rsp_mon,
    output int         mismatch_count,
    output int         pending_count,
    output logic [7:0] model_pc
);

    typedef struct packed {
        logic [7:0] pc;
        logic [7:0] acc;
        logic       neg;
        logic       zero;
        logic [7:0] read_data;
        logic [1:0] status;
    } cpu_view_t;

    cpu_view_t  owed_results[$];
    logic [7:0] mem_model [0:MEM_BYTES-1];
    logic [7:0] cpu_pc;
    logic [7:0] cpu_acc;
    logic       cpu_neg;
    logic       cpu_zero;
    logic       cpu_stopped;

    task automatic run_request(input logic [1:0] kind, input logic [7:0] addr,
                               input logic [7:0] wdata, output cpu_view_t view);
        logic [7:0] opc;
        logic [7:0] opr;
        logic [7:0] opr_addr;
        logic [7:0] next2;
        logic       acc_written;
        view.read_data = 8'h00;
        view.status    = ST_OK;
        acc_written    = 1'b0;
        case (kind)
            REQ_WRITE: mem_model[addr] = wdata;
            REQ_READ:  view.read_data = mem_model[addr];
            REQ_EXEC:
            begin
                if (cpu_stopped)
                begin
                    view.status = ST_IGNORED;
                end
                else
                begin
                    // operand fetch wraps past the last byte
                    opr_addr = cpu_pc + 8'd1;
                    next2    = cpu_pc + 8'd2;
                    opc      = mem_model[cpu_pc];
                    opr      = mem_model[opr_addr];
                    case (opc)
                        OP_NOP: cpu_pc = opr_addr;
                        OP_STA:
                        begin
                            mem_model[opr] = cpu_acc;
                            cpu_pc = next2;
                        end
                        OP_LDA:
                        begin
                            cpu_acc = mem_model[opr];
                            acc_written = 1'b1;
                            cpu_pc = next2;
                        end
                        OP_ADD:
                        begin
                            cpu_acc = cpu_acc + mem_model[opr];
                            acc_written = 1'b1;
                            cpu_pc = next2;
                        end
                        OP_OR:
                        begin
                            cpu_acc = cpu_acc | mem_model[opr];
                            acc_written = 1'b1;
                            cpu_pc = next2;
                        end
                        OP_AND:
                        begin
                            cpu_acc = cpu_acc & mem_model[opr];
                            acc_written = 1'b1;
                            cpu_pc = next2;
                        end
                        OP_NOT:
                        begin
                            cpu_acc = ~cpu_acc;
                            acc_written = 1'b1;
                            cpu_pc = opr_addr;
                        end
                        OP_JMP: cpu_pc = opr;
                        OP_JN:  cpu_pc = cpu_neg ? opr : next2;
                        OP_JZ:  cpu_pc = cpu_zero ? opr : next2;
                        OP_HLT:
                        begin
                            cpu_stopped = 1'b1;
                            view.status = ST_HALT;
                        end
                        default:
                        begin
                            cpu_stopped = 1'b1;
                            view.status = ST_UNKNOWN;
                        end
                    endcase
                    if (acc_written)
                    begin
                        cpu_neg  = cpu_acc[7];
                        cpu_zero = (cpu_acc == 8'h00);
                    end
                end
            end
            default: ;
        endcase
        view.pc   = cpu_pc;
        view.acc  = cpu_acc;
        view.neg  = cpu_neg;
        view.zero = cpu_zero;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got, inout int errs);
        if (got !== want)
        begin
            $display("%0t ERROR %s: expected %0h, actual %0h", $time, name, want, got);
            errs++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        int        errs;
        cpu_view_t want;
        cpu_view_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_BYTES; i++)
                mem_model[i] = 8'h00;
            cpu_pc      = 8'h00;
            cpu_acc     = 8'h00;
            cpu_neg     = 1'b0;
            cpu_zero    = 1'b0;
            cpu_stopped = 1'b0;
            owed_results.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
            model_pc       <= 8'h00;
        end
        else
        begin
            errs = 0;
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t ERROR result transfer with no request owed: pc %0h acc %0h",
                             $time, rsp_mon.program_count, rsp_mon.accum);
                    errs++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    compare_field("program_count", want.pc, rsp_mon.program_count, errs);
                    compare_field("accum", want.acc, rsp_mon.accum, errs);
                    compare_field("negative_flag", {7'd0, want.neg},
                                  {7'd0, rsp_mon.negative_flag}, errs);
                    compare_field("zero_flag", {7'd0, want.zero},
                                  {7'd0, rsp_mon.zero_flag}, errs);
                    compare_field("read_data", want.read_data, rsp_mon.read_data, errs);
                    compare_field("status", {6'd0, want.status}, {6'd0, rsp_mon.status}, errs);
                end
            end
            if (req_mon.valid && req_mon.ready)
            begin
                run_request(req_mon.req_type, req_mon.address, req_mon.write_data, fresh);
                owed_results.push_back(fresh);
            end
            mismatch_count <= mismatch_count + errs;
            pending_count  <= owed_results.size();
            model_pc       <= cpu_pc;
        end
    end

endmodule

>>> test/accumulator_cpu_core_tb.sv
// ----------------------------------------------------------------------------
// accumulator_cpu_core_tb
// Drives the accumulator processor core with a short directed program that
// walks the flags, the jumps and the wrap at the last address, then with
// random small programs written at the current pc and executed, mixed with
// stray reads, writes and unused requests. The run ends by stopping the
// core on HLT or an unknown opcode and checking that later executes are
// ignored. The sender works in bursts, the receiver stalls on its own
// pattern with long hold-offs; a checker beside the core does the compare.
// ----------------------------------------------------------------------------
module accumulator_cpu_core_tb;
    import acc_cpu_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         RANDOM_REQS = 830;

    logic       clk;
    logic       rst_n;
    int         mismatch_count;
    int         pending_count;
    logic [7:0] model_pc;
    int         burst_left;
    int         req_count;
    bit         last_was_exec;
    int         quiet_cycles;

    acc_cpu_req_if req_ch();
    acc_cpu_rsp_if rsp_ch();

    accumulator_cpu_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    acc_cpu_result_checker u_result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_mon        (req_ch),
        .rsp_mon        (rsp_ch),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .model_pc       (model_pc)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic send_req(input logic [1:0] kind, input logic [7:0] addr,
                            input logic [7:0] data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= kind;
        req_ch.address    <= addr;
        req_ch.write_data <= data;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        req_count++;
        last_was_exec = (kind == REQ_EXEC);
    endtask

    // the model pc is registered in the checker; wait for it after an execute transfer
    task automatic wait_model_pc();
        if (last_was_exec)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
            last_was_exec = 1'b0;
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        last_was_exec = 1'b0;
    endtask

    // straight-line program at the pc, a jump allowed only as the last one
    task automatic run_program_group();
        logic [7:0] base;
        logic [7:0] at_addr;
        logic [7:0] opc;
        logic [7:0] opr;
        int         n_instr;
        int         pick;
        wait_model_pc();
        base    = model_pc;
        at_addr = base;
        n_instr = $urandom_range(1, 6);
        for (int k = 0; k < n_instr; k++)
        begin
            pick = (k == n_instr - 1) ? $urandom_range(0, 9) : $urandom_range(0, 6);
            case (pick)
                0:       opc = OP_NOP;
                1:       opc = OP_STA;
                2:       opc = OP_LDA;
                3:       opc = OP_ADD;
                4:       opc = OP_OR;
                5:       opc = OP_AND;
                6:       opc = OP_NOT;
                7:       opc = OP_JMP;
                8:       opc = OP_JN;
                default: opc = OP_JZ;
            endcase
            send_req(REQ_WRITE, at_addr, opc);
            if (opc != OP_NOP && opc != OP_NOT)
            begin
                // stores stay clear of the program bytes
                if (opc == OP_STA)
                    opr = base + 8'd12 + 8'($urandom_range(0, 243));
                else
                    opr = 8'($urandom);
                send_req(REQ_WRITE, at_addr + 8'd1, opr);
                at_addr = at_addr + 8'd2;
            end
            else
            begin
                at_addr = at_addr + 8'd1;
            end
        end
        if ($urandom_range(0, 15) == 0)
            return;
        for (int k = 0; k < n_instr; k++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_req($urandom_range(0, 1) ? REQ_READ : REQ_UNUSED,
                         8'($urandom), 8'($urandom));
            send_req(REQ_EXEC, 8'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int         pick;
        int         next_pause;
        logic [7:0] stop_opc;
        bit         known;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_WRITE;
        req_ch.address    = 8'h00;
        req_ch.write_data = 8'h00;
        burst_left        = 0;
        req_count         = 0;
        last_was_exec     = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed program
        send_req(REQ_READ, 8'hFF, 8'h00);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_UNUSED, 8'hFF, 8'hFF);
        send_req(REQ_WRITE, 8'hFE, 8'h80);
        send_req(REQ_WRITE, 8'h01, OP_LDA);
        send_req(REQ_WRITE, 8'h02, 8'hFE);
        send_req(REQ_EXEC, 8'hFF, 8'hFF);
        send_req(REQ_WRITE, 8'h03, OP_ADD);
        send_req(REQ_WRITE, 8'h04, 8'hFE);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_WRITE, 8'h05, OP_JZ);
        send_req(REQ_WRITE, 8'h06, 8'hFF);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_WRITE, 8'hFF, OP_NOT);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_WRITE, 8'h00, OP_JN);
        send_req(REQ_WRITE, 8'h01, 8'hFD);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_WRITE, 8'hFD, OP_STA);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_WRITE, 8'hFF, OP_AND);
        send_req(REQ_EXEC, 8'h00, 8'h00);
        send_req(REQ_READ, 8'h80, 8'h00);
        send_req(REQ_READ, 8'hFF, 8'h00);

        // random programs and stray traffic
        next_pause = 350;
        while (req_count < RANDOM_REQS)
        begin
            if (req_count >= next_pause)
            begin
                drain_results();
                next_pause += 300;
            end
            pick = $urandom_range(0, 19);
            if (pick < 15)
                run_program_group();
            else if (pick < 17)
                send_req(REQ_WRITE, 8'($urandom), 8'($urandom));
            else if (pick < 19)
                send_req(REQ_READ, 8'($urandom), 8'($urandom));
            else
                send_req(REQ_UNUSED, 8'($urandom), 8'($urandom));
        end

        // stop the core, then only memory access does anything
        wait_model_pc();
        if ($urandom_range(0, 1))
        begin
            stop_opc = OP_HLT;
        end
        else
        begin
            do
            begin
                stop_opc = 8'($urandom);
                case (stop_opc)
                    OP_NOP, OP_STA, OP_LDA, OP_ADD, OP_OR, OP_AND, OP_NOT,
                    OP_JMP, OP_JN, OP_JZ, OP_HLT: known = 1'b1;
                    default: known = 1'b0;
                endcase
            end
            while (known);
        end
        send_req(REQ_WRITE, model_pc, stop_opc);
        send_req(REQ_EXEC, 8'($urandom), 8'($urandom));
        repeat (16)
        begin
            pick = $urandom_range(0, 3);
            case (pick)
                0:       send_req(REQ_EXEC, 8'($urandom), 8'($urandom));
                1:       send_req(REQ_READ, 8'($urandom), 8'($urandom));
                2:       send_req(REQ_WRITE, 8'($urandom), 8'($urandom));
                default: send_req(REQ_UNUSED, 8'($urandom), 8'($urandom));
            endcase
        end
        send_req(REQ_EXEC, 8'hFF, 8'h00);

        drain_results();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver: random stall runs plus a long hold-off now and then
    initial
    begin
        int  rsp_taken;
        int  next_hold_at;
        int  hold_left;
        int  run_left;
        int  rx_mode;
        bit  ready_next;
        rsp_ch.ready = 1'b0;
        rsp_taken    = 0;
        next_hold_at = 150;
        hold_left    = 0;
        run_left     = 0;
        rx_mode      = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                rsp_taken++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (rsp_taken >= next_hold_at)
            begin
                hold_left    = 240;
                next_hold_at += 300;
                ready_next   = 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    rx_mode  = $urandom_range(0, 3);
                    run_left = $urandom_range(4, 64);
                end
                run_left--;
                case (rx_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    2:       ready_next = ($urandom_range(0, 3) != 0);
                    default: ready_next = ($urandom_range(0, 7) == 0);
                endcase
            end
            rsp_ch.ready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule

>>> filelist.f
rtl/core/acc_cpu_pkg.sv
rtl/core/acc_cpu_ifs.sv
rtl/core/acc_cpu_ctrl.sv
rtl/core/acc_cpu_dp.sv
rtl/core/accumulator_cpu_core.sv
test/acc_cpu_result_checker.sv
test/accumulator_cpu_core_tb.sv
